FILE: rtl/core/sha1_pkg.sv
`timescale 1ns / 1ps
package sha1_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_ABSORB   = 2'd0;
    localparam logic [1:0] OP_FINALIZE = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;

    // SHA-1 initial chaining value.
    localparam logic [31:0] IV_H0 = 32'h67452301;
    localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_H2 = 32'h98BADCFE;
    localparam logic [31:0] IV_H3 = 32'h10325476;
    localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    // Padding marker byte.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Input request payload.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in_req;

    // Output request payload.
    typedef struct packed {
        logic [31:0] digest_h0;
        logic [31:0] digest_h1;
        logic [31:0] digest_h2;
        logic [31:0] digest_h3;
        logic [31:0] digest_h4;
    } t_out_req;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    // Kind of compression in progress.
    typedef enum logic [1:0] {
        JOB_BLOCK,
        JOB_FIN1,
        JOB_FIN2
    } t_job;

    // Source of the 16 message words loaded into the schedule window.
    typedef enum logic [1:0] {
        SRC_BUF,
        SRC_PAD,
        SRC_LEN
    } t_blk_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     absorb;
        logic     restart;
        logic     load;
        t_blk_src src;
        logic     base_h;
        logic     round;
        logic     add;
        logic     commit;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_full;
        logic two_blocks;
        logic last_round;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: rtl/core/sha1_dp.sv
`timescale 1ns / 1ps
module sha1_dp
    import sha1_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_req  i_in_req,
    input  t_dp_cmd  i_cmd,
    input  logic     i_out_ready,
    output t_dp_sts  o_sts,
    output logic     o_out_valid,
    output t_out_req o_out_req
);

    logic [31:0] r_h   [5];
    logic [31:0] r_fh  [5];
    logic [31:0] r_buf [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_cnt;
    logic [60:0] r_bytes;
    logic [6:0]  r_t;
    logic        r_out_valid;
    t_out_req    r_out;

    logic [31:0] w_pad [16];
    logic [31:0] w_src [16];
    logic [31:0] w_base [5];
    logic [63:0] w_len;
    logic [31:0] w_f, w_k, w_tmp, w_next_w;

    // Message length in bits, big-endian in the last two words.
    assign w_len = {r_bytes, 3'b000};

    // Padded final block: buffered bytes, the marker byte, zeros, and the
    // length when it still fits behind the marker.
    always_comb begin
        logic [5:0] idx;
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
                idx = 6'(4 * i + j);
                if (idx < r_cnt) begin
                    w_pad[i][31 - 8 * j -: 8] = r_buf[i][31 - 8 * j -: 8];
                end else if (idx == r_cnt) begin
                    w_pad[i][31 - 8 * j -: 8] = PAD_BYTE;
                end else begin
                    w_pad[i][31 - 8 * j -: 8] = 8'h00;
                end
            end
        end
        if (!o_sts.two_blocks) begin
            w_pad[14] = w_len[63:32];
            w_pad[15] = w_len[31:0];
        end
    end

    // Block source selection for the schedule window load.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            unique case (i_cmd.src)
                SRC_BUF: w_src[i] = r_buf[i];
                SRC_PAD: w_src[i] = w_pad[i];
                default: w_src[i] = 32'h0;
            endcase
        end
        w_src[14] = (i_cmd.src == SRC_LEN) ? w_len[63:32] : w_src[14];
        w_src[15] = (i_cmd.src == SRC_LEN) ? w_len[31:0]  : w_src[15];
        for (int i = 0; i < 5; i++) begin
            w_base[i] = i_cmd.base_h ? r_h[i] : r_fh[i];
        end
    end

    // One SHA-1 round and the next schedule word.
    always_comb begin
        if (r_t < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_R0;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_R2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R3;
        end
        w_tmp    = {r_a[26:0], r_a[31:27]} + w_f + r_e + r_w[0] + w_k;
        w_next_w = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_next_w = {w_next_w[30:0], w_next_w[31]};
    end

    // Byte buffer, counters and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0]  <= IV_H0;
            r_h[1]  <= IV_H1;
            r_h[2]  <= IV_H2;
            r_h[3]  <= IV_H3;
            r_h[4]  <= IV_H4;
            r_cnt   <= 6'd0;
            r_bytes <= 61'd0;
        end else begin
            if (i_cmd.absorb) begin
                for (int i = 0; i < 16; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        if (r_cnt == 6'(4 * i + j)) begin
                            r_buf[i][31 - 8 * j -: 8] <= i_in_req.data_byte;
                        end
                    end
                end
                r_cnt   <= r_cnt + 6'd1;
                r_bytes <= r_bytes + 61'd1;
            end
            if (i_cmd.restart) begin
                r_h[0]  <= IV_H0;
                r_h[1]  <= IV_H1;
                r_h[2]  <= IV_H2;
                r_h[3]  <= IV_H3;
                r_h[4]  <= IV_H4;
                r_cnt   <= 6'd0;
                r_bytes <= 61'd0;
            end
            if (i_cmd.add && i_cmd.commit) begin
                r_h[0] <= r_fh[0] + r_a;
                r_h[1] <= r_fh[1] + r_b;
                r_h[2] <= r_fh[2] + r_c;
                r_h[3] <= r_fh[3] + r_d;
                r_h[4] <= r_fh[4] + r_e;
            end
        end
    end

    // Round counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= 7'd0;
        end else if (i_cmd.load) begin
            r_t <= 7'd0;
        end else if (i_cmd.round) begin
            r_t <= r_t + 7'd1;
        end
    end

    // Working hash, round registers and schedule window.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= w_src[i];
            end
            for (int i = 0; i < 5; i++) begin
                r_fh[i] <= w_base[i];
            end
            r_a <= w_base[0];
            r_b <= w_base[1];
            r_c <= w_base[2];
            r_d <= w_base[3];
            r_e <= w_base[4];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_next_w;
            r_a <= w_tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else if (i_cmd.add) begin
            r_fh[0] <= r_fh[0] + r_a;
            r_fh[1] <= r_fh[1] + r_b;
            r_fh[2] <= r_fh[2] + r_c;
            r_fh[3] <= r_fh[3] + r_d;
            r_fh[4] <= r_fh[4] + r_e;
        end
    end

    // Output register, decoupled from the input side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.digest_h0 <= r_fh[0];
            r_out.digest_h1 <= r_fh[1];
            r_out.digest_h2 <= r_fh[2];
            r_out.digest_h3 <= r_fh[3];
            r_out.digest_h4 <= r_fh[4];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_req         = r_out;
    assign o_sts.block_full  = (r_cnt == 6'd63);
    assign o_sts.two_blocks  = (r_cnt >= 6'd56);
    assign o_sts.last_round  = (r_t == 7'd79);
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

endmodule

FILE: rtl/core/sha1_ctrl.sv
`timescale 1ns / 1ps
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    input  t_dp_sts    i_sts,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_job   r_job, n_job;

    // State and job registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_BLOCK;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        o_cmd      = '0;
        o_cmd.src  = SRC_BUF;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_ABSORB: begin
                            o_cmd.absorb = 1'b1;
                            if (i_sts.block_full) begin
                                n_job   = JOB_BLOCK;
                                n_state = S_LOAD;
                            end
                        end
                        OP_FINALIZE: begin
                            n_job   = JOB_FIN1;
                            n_state = S_LOAD;
                        end
                        OP_RESTART: begin
                            o_cmd.restart = 1'b1;
                        end
                        default: begin
                            // Unused opcode: the request is dropped.
                        end
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                unique case (r_job)
                    JOB_BLOCK: o_cmd.src = SRC_BUF;
                    JOB_FIN1:  o_cmd.src = SRC_PAD;
                    default:   o_cmd.src = SRC_LEN;
                endcase
                o_cmd.base_h = (r_job != JOB_FIN2);
                n_state      = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.last_round) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add    = 1'b1;
                o_cmd.commit = (r_job == JOB_BLOCK);
                if (r_job == JOB_BLOCK) begin
                    n_state = S_IDLE;
                end else if (r_job == JOB_FIN1 && i_sts.two_blocks) begin
                    n_job   = JOB_FIN2;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/sha1_hash_engine_unit.sv
`timescale 1ns / 1ps
// SHA-1 hashing engine fed one request at a time: absorb one message byte,
// finalize (emit the five big-endian digest words without disturbing the
// running hash, so absorbing may continue), or restart. The byte that
// completes a 64-byte block starts a compression (a load, 80 rounds, an add)
// that runs one SHA-1 round per cycle through a single round unit, and no
// request is accepted until it is done. A finalize compresses the padded
// block, plus a second padding block when 56 or more bytes are buffered,
// then waits for the previous digest to be taken before it loads its own;
// the next request is accepted once that digest is loaded. The digest sits in
// its own output register so input requests continue meanwhile. Restart and
// the unused opcode start no compression.
module sha1_hash_engine_unit
    import sha1_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencing of loads, rounds and output.
    sha1_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_req.opcode),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Buffer, schedule, round logic and output register.
    sha1_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

    // No digest is pending right after reset.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("digest valid after reset");

    // A finalize request always starts a compression before any new request.
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_req.opcode == OP_FINALIZE) |=> !o_in_ready)
        else $error("finalize did not start compression");

    // The byte that fills the block starts a compression.
    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_req.opcode == OP_ABSORB && w_sts.block_full)
        |=> !o_in_ready)
        else $error("full block not compressed");

    // A digest appears only when the controller loads the output register.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("digest valid without output load");

endmodule

FILE: bench/tb_sha1_hash_engine_unit.sv
`timescale 1ns / 1ps
module tb_sha1_hash_engine_unit
    import sha1_pkg::*;
;

    // Opcode that the engine must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Longest stretch of cycles with no request moving on either side.
    localparam int QUIET_LIMIT = 4000;
    // Cycles allowed after the last digest for stray output.
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_REQUESTS = 460;
    // Fewest digests each random phase asks for.
    localparam int PHASE_DIGESTS = 8;

    // Predicts SHA-1 digests from the accepted requests and checks the output against them.
    class sha1_digest_scoreboard;
        logic [159:0] chain;
        logic [7:0]   held [64];
        int unsigned  held_count;
        logic [60:0]  total_bytes;
        t_out_req     digest_q [$];
        int unsigned  absorbs, finalizes, restarts, ignored, blocks, checked, errors;

        function new();
            load_initial_value();
        endfunction

        function void load_initial_value();
            chain = {IV_H0, IV_H1, IV_H2, IV_H3, IV_H4};
            held_count = 0;
            total_bytes = '0;
        endfunction

        // One 80-round compression of a 512-bit block, first message byte in the top bits.
        function logic [159:0] compress_block(logic [159:0] h_in, logic [511:0] blk);
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, x, sum;
            for (int t = 0; t < 16; t++) begin
                w[t] = blk[511 - 32 * t -: 32];
            end
            {a, b, c, d, e} = h_in;
            for (int t = 0; t < 80; t++) begin
                if (t >= 16) begin
                    x = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
                    w[t % 16] = {x[30:0], x[31]};
                end
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = K_R0;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = K_R1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_R2;
                end else begin
                    f = b ^ c ^ d;
                    k = K_R3;
                end
                sum = {a[26:0], a[31:27]} + f + e + w[t % 16] + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = sum;
            end
            return {h_in[159:128] + a, h_in[127:96] + b, h_in[95:64] + c,
                    h_in[63:32] + d, h_in[31:0] + e};
        endfunction

        function int unsigned useful_requests();
            return absorbs + finalizes + restarts;
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction

        // Update the running hash for one accepted request; a finalize queues its digest.
        function void note_request(t_in_req req);
            logic [511:0] blk;
            logic [159:0] h;
            case (req.opcode)
                OP_ABSORB: begin
                    absorbs++;
                    held[held_count] = req.data_byte;
                    held_count++;
                    total_bytes = total_bytes + 61'd1;
                    if (held_count == 64) begin
                        for (int i = 0; i < 64; i++) begin
                            blk[511 - 8 * i -: 8] = held[i];
                        end
                        chain = compress_block(chain, blk);
                        held_count = 0;
                        blocks++;
                    end
                end
                OP_RESTART: begin
                    restarts++;
                    load_initial_value();
                end
                OP_FINALIZE: begin
                    // Pad a copy of the state; the running hash is left untouched.
                    finalizes++;
                    blk = '0;
                    for (int i = 0; i < held_count; i++) begin
                        blk[511 - 8 * i -: 8] = held[i];
                    end
                    blk[511 - 8 * held_count -: 8] = PAD_BYTE;
                    h = chain;
                    if (held_count + 1 > 56) begin
                        h = compress_block(h, blk);
                        blk = '0;
                    end
                    blk[63:0] = {total_bytes, 3'b000};
                    h = compress_block(h, blk);
                    digest_q.push_back(h);
                end
                default: begin
                    ignored++;
                end
            endcase
        endfunction

        function void compare_word(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %08h, got %08h", field, want, got);
                errors++;
            end
        endfunction

        // Compare one output digest with the oldest outstanding finalize.
        function void check_digest(t_out_req got);
            t_out_req want;
            if (digest_q.size() == 0) begin
                $error("digest received with no finalize outstanding: %040h", got);
                errors++;
                return;
            end
            want = digest_q.pop_front();
            checked++;
            compare_word("digest_h0", want.digest_h0, got.digest_h0);
            compare_word("digest_h1", want.digest_h1, got.digest_h1);
            compare_word("digest_h2", want.digest_h2, got.digest_h2);
            compare_word("digest_h3", want.digest_h3, got.digest_h3);
            compare_word("digest_h4", want.digest_h4, got.digest_h4);
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_ready;
    t_out_req out_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    sha1_digest_scoreboard sb = new();

    sha1_hash_engine_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    always #2 clk = ~clk;

    // Present one request, after an optional random gap, and hold it until accepted.
    task automatic send_request(input logic [1:0] op, input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= '{opcode: op, data_byte: data};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(in_req);
    endtask

    // Stop sending and wait until every queued digest has come out.
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Random messages of mixed lengths, each closed by a finalize, with some noise mixed in.
    task automatic run_phase(input int requests_wanted);
        int unsigned stop_requests;
        int unsigned stop_digests;
        int msg_len;
        stop_requests = sb.useful_requests() + requests_wanted;
        stop_digests = sb.finalizes + PHASE_DIGESTS;
        while (sb.useful_requests() < stop_requests || sb.finalizes < stop_digests) begin
            // Lengths cluster near the one- and two-block padding boundary.
            case ($urandom_range(0, 9))
                0, 1, 2, 3: msg_len = $urandom_range(0, 8);
                4, 5, 6: msg_len = $urandom_range(52, 68);
                7, 8: msg_len = $urandom_range(0, 140);
                default: msg_len = $urandom_range(120, 200);
            endcase
            for (int i = 0; i < msg_len; i++) begin
                if ($urandom_range(0, 99) < 4) send_request(OP_UNUSED, 8'($urandom));
                if ($urandom_range(0, 199) == 0) send_request(OP_RESTART, 8'($urandom));
                send_request(OP_ABSORB, 8'($urandom));
            end
            send_request(OP_FINALIZE, 8'($urandom));
            if ($urandom_range(0, 4) == 0) send_request(OP_FINALIZE, 8'($urandom));
            // Otherwise the next message continues the same running hash.
            if ($urandom_range(0, 9) < 6) send_request(OP_RESTART, 8'($urandom));
        end
    endtask

    // Output side: check each accepted digest, then pick the next ready value.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_digest(out_req);
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on cycles where no request moves on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_req <= '0;
        out_ready <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, repeated finalize, ignored opcode, "abc", byte extremes.
        send_request(OP_RESTART, 8'h00);
        send_request(OP_FINALIZE, 8'h00);
        send_request(OP_FINALIZE, 8'hFF);
        send_request(OP_UNUSED, 8'hFF);
        send_request(OP_ABSORB, 8'h61);
        send_request(OP_ABSORB, 8'h62);
        send_request(OP_ABSORB, 8'h63);
        send_request(OP_FINALIZE, 8'h00);
        send_request(OP_FINALIZE, 8'h00);
        send_request(OP_ABSORB, 8'h00);
        send_request(OP_ABSORB, 8'hFF);
        send_request(OP_UNUSED, 8'h00);
        send_request(OP_FINALIZE, 8'h00);
        send_request(OP_RESTART, 8'hFF);
        send_request(OP_FINALIZE, 8'h00);
        send_request(OP_ABSORB, 8'h80);
        send_request(OP_FINALIZE, 8'h00);
        wait_for_digests();

        // Slow receiver, then slow sender, then full rate on both sides.
        send_idle_pct = 8;
        recv_idle_pct = 84;
        run_phase(PHASE_REQUESTS);
        wait_for_digests();
        send_idle_pct = 84;
        recv_idle_pct = 8;
        run_phase(PHASE_REQUESTS);
        wait_for_digests();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(PHASE_REQUESTS);
        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d absorbs, %0d finalizes, %0d restarts and %0d unused-opcode requests.",
                 sb.absorbs, sb.finalizes, sb.restarts, sb.ignored);
        $display("Checked %0d digests; %0d full message blocks were compressed on the way.",
                 sb.checked, sb.blocks);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_dp.sv
rtl/core/sha1_ctrl.sv
rtl/core/sha1_hash_engine_unit.sv
bench/tb_sha1_hash_engine_unit.sv
